// ===== design/pcfc_pkg.sv =====
// shared types and constants for the protocol classifier and flow counter
`timescale 1ns / 1ps

package pcfc_pkg;

  // command codes on func
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_INSTALL = 1'b1;

  // configuration register word index (paddr[2])
  localparam logic REG_L2_CODE = 1'b0;
  localparam logic [7:0] L2_CODE_RESET = 8'd1;

  // ethertypes of interest
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  // header byte positions
  localparam logic [15:0] POS_ET_HI    = 16'd12;
  localparam logic [15:0] POS_ET_LO    = 16'd13;
  localparam logic [15:0] POS_V6_NH    = 16'd20;
  localparam logic [15:0] POS_V4_PROTO = 16'd23;

  // minimum lengths for a field to count
  localparam logic [15:0] MIN_ET_LEN = 16'd14;
  localparam logic [15:0] MIN_V4_LEN = 16'd34;
  localparam logic [15:0] MIN_V6_LEN = 16'd54;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CRD,
    S_CUPD
  } state_t;

  // packet summary handed from parser to lookup
  typedef struct packed {
    logic [15:0] et;
    logic [7:0]  l4;
    logic [15:0] len;
  } pkt_info_t;

  // one key table entry
  typedef struct packed {
    logic        valid;
    logic [7:0]  l2;
    logic [15:0] et;
    logic [7:0]  l4;
  } key_entry_t;

endpackage

// ===== design/pcfc_parser.sv =====
// per-byte header parser: length, ethertype and layer-4 protocol capture
`timescale 1ns / 1ps

module pcfc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_en,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output pcfc_pkg::pkt_info_t   info
);

  logic [15:0] byte_position;
  logic [15:0] seen_ethertype;
  logic [7:0]  seen_l4;
  logic [15:0] byte_position_next;
  logic [15:0] seen_ethertype_next;
  logic [7:0]  seen_l4_next;

  // header capture for the byte at the current position
  always_comb begin
    seen_ethertype_next = seen_ethertype;
    seen_l4_next = seen_l4;
    if (byte_position == pcfc_pkg::POS_ET_HI) begin
      seen_ethertype_next = {data_byte, seen_ethertype[7:0]};
    end else if (byte_position == pcfc_pkg::POS_ET_LO) begin
      seen_ethertype_next = {seen_ethertype[15:8], data_byte};
    end else if (byte_position == pcfc_pkg::POS_V6_NH &&
                 seen_ethertype == pcfc_pkg::ETH_IPV6) begin
      seen_l4_next = data_byte;
    end else if (byte_position == pcfc_pkg::POS_V4_PROTO &&
                 seen_ethertype == pcfc_pkg::ETH_IPV4) begin
      seen_l4_next = data_byte;
    end
    byte_position_next = (byte_position != pcfc_pkg::LEN_MAX) ?
                         byte_position + 16'd1 : byte_position;
  end

  // packet summary as it stands after this byte
  always_comb begin
    info.len = byte_position_next;
    info.et  = (byte_position_next >= pcfc_pkg::MIN_ET_LEN) ? seen_ethertype_next : 16'd0;
    info.l4  = 8'd0;
    if (info.et == pcfc_pkg::ETH_IPV4 && byte_position_next >= pcfc_pkg::MIN_V4_LEN) begin
      info.l4 = seen_l4_next;
    end else if (info.et == pcfc_pkg::ETH_IPV6 &&
                 byte_position_next >= pcfc_pkg::MIN_V6_LEN) begin
      info.l4 = seen_l4_next;
    end
  end

  // packet state, cleared at the end of each packet
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      seen_ethertype <= '0;
      seen_l4        <= '0;
    end else if (byte_en) begin
      if (last_byte) begin
        byte_position  <= '0;
        seen_ethertype <= '0;
        seen_l4        <= '0;
      end else begin
        byte_position  <= byte_position_next;
        seen_ethertype <= seen_ethertype_next;
        seen_l4        <= seen_l4_next;
      end
    end
  end

endmodule

// ===== design/protocol_classifier_flow_counter.sv =====
// top level: command port, key table search and per-slot counters
`timescale 1ns / 1ps

// Ethernet protocol classifier with per-slot packet and byte counters. A packet
// byte or a table install is taken when start is high and busy is low. The last
// byte of a packet starts a search of the key table, one slot per cycle through a
// single key comparator on a registered memory read: busy stays high until the
// first matching slot is found and then through a counter read and a 64-bit
// read-modify-write, or until every slot has missed. The result shows on the
// output ports with done high for exactly one cycle, in the same cycle that busy
// falls; it cannot be held off. After reset a clearing pass runs through the table
// with busy high; configuration writes are taken throughout.
module protocol_classifier_flow_counter #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [7:0]  entry_index,
  input  logic        entry_valid,
  input  logic [7:0]  entry_l2,
  input  logic [15:0] entry_ethertype,
  input  logic [7:0]  entry_l4,
  // result side
  output logic        done,
  output logic [15:0] ethertype,
  output logic [7:0]  l4_protocol,
  output logic [15:0] packet_length,
  output logic        hit,
  output logic [7:0]  matched_index,
  output logic [63:0] packet_count,
  output logic [63:0] byte_count,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EXT_W = IDX_W + 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   N_ENTRIES = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [EXT_W-1:0] N_ENTRIES_EXT = EXT_W'(TABLE_ENTRIES);

  pcfc_pkg::state_t    state;
  pcfc_pkg::state_t    state_next;
  logic [7:0]          l2_code;
  pcfc_pkg::pkt_info_t info;
  pcfc_pkg::pkt_info_t cur;

  // table memories
  pcfc_pkg::key_entry_t key_mem [TABLE_ENTRIES];
  logic [63:0]          pc_mem  [TABLE_ENTRIES];
  logic [63:0]          bc_mem  [TABLE_ENTRIES];

  pcfc_pkg::key_entry_t key_rd;
  logic [63:0]          pc_rd;
  logic [63:0]          bc_rd;

  // sequencer registers
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W:0]   issue_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_pend;
  logic [IDX_W-1:0] hit_idx;

  // control terms
  logic             accept;
  logic             byte_acc;
  logic             inst_acc;
  logic             issue;
  logic             key_match;
  logic             hit_now;
  logic             miss_now;
  logic             cfg_wr;
  logic [EXT_W-1:0] slot_ext;
  logic             slot_ok;
  logic [EXT_W-1:0] hit_idx_ext;

  // write ports
  logic                 key_we;
  logic [IDX_W-1:0]     key_wa;
  pcfc_pkg::key_entry_t key_wd;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_wa;
  logic [63:0]          pc_wd;
  logic [63:0]          bc_wd;

  pcfc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_acc),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .info      (info)
  );

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == pcfc_pkg::REG_L2_CODE) ? {24'd0, l2_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_code <= pcfc_pkg::L2_CODE_RESET;
    end else if (cfg_wr && paddr[2] == pcfc_pkg::REG_L2_CODE) begin
      l2_code <= pwdata[7:0];
    end
  end

  // command decode
  assign busy     = (state != pcfc_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign byte_acc = accept && func == pcfc_pkg::FUNC_BYTE;
  assign inst_acc = accept && func == pcfc_pkg::FUNC_INSTALL;
  assign slot_ext = EXT_W'(entry_index);
  assign slot_ok  = slot_ext < N_ENTRIES_EXT;

  // shared key comparator on the registered table read
  assign key_match = key_rd.valid && key_rd.l2 == l2_code &&
                     key_rd.et == cur.et && key_rd.l4 == cur.l4;
  assign issue    = (state == pcfc_pkg::S_SCAN) && (issue_cnt < N_ENTRIES);
  assign hit_now  = (state == pcfc_pkg::S_SCAN) && rd_pend && key_match;
  assign miss_now = (state == pcfc_pkg::S_SCAN) && rd_pend && !key_match &&
                    rd_addr == LAST_IDX;

  assign hit_idx_ext = EXT_W'(hit_idx);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pcfc_pkg::S_CLEAR: begin
        if (clr_addr == LAST_IDX) begin
          state_next = pcfc_pkg::S_IDLE;
        end
      end
      pcfc_pkg::S_IDLE: begin
        if (byte_acc && last_byte) begin
          state_next = pcfc_pkg::S_SCAN;
        end
      end
      pcfc_pkg::S_SCAN: begin
        if (hit_now) begin
          state_next = pcfc_pkg::S_CRD;
        end else if (miss_now) begin
          state_next = pcfc_pkg::S_IDLE;
        end
      end
      pcfc_pkg::S_CRD:  state_next = pcfc_pkg::S_CUPD;
      pcfc_pkg::S_CUPD: state_next = pcfc_pkg::S_IDLE;
      default:          state_next = pcfc_pkg::S_CLEAR;
    endcase
  end

  // write port selection: clearing pass, install, counter update
  always_comb begin
    key_we = 1'b0;
    key_wa = slot_ext[IDX_W-1:0];
    key_wd = '0;
    cnt_we = 1'b0;
    cnt_wa = slot_ext[IDX_W-1:0];
    pc_wd  = 64'd0;
    bc_wd  = 64'd0;
    if (state == pcfc_pkg::S_CLEAR) begin
      key_we = 1'b1;
      key_wa = clr_addr;
      cnt_we = 1'b1;
      cnt_wa = clr_addr;
    end else if (state == pcfc_pkg::S_CUPD) begin
      cnt_we = 1'b1;
      cnt_wa = hit_idx;
      pc_wd  = pc_rd + 64'd1;
      bc_wd  = bc_rd + 64'(cur.len);
    end else if (inst_acc && slot_ok) begin
      key_we       = 1'b1;
      key_wd.valid = entry_valid;
      key_wd.l2    = entry_l2;
      key_wd.et    = entry_ethertype;
      key_wd.l4    = entry_l4;
      cnt_we       = 1'b1;
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd <= key_mem[issue_cnt[IDX_W-1:0]];
  end

  // counter memories
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      pc_mem[cnt_wa] <= pc_wd;
      bc_mem[cnt_wa] <= bc_wd;
    end
    pc_rd <= pc_mem[hit_idx];
    bc_rd <= bc_mem[hit_idx];
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcfc_pkg::S_CLEAR;
      clr_addr  <= '0;
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= miss_now || (state == pcfc_pkg::S_CUPD);
      if (state == pcfc_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == pcfc_pkg::S_IDLE) begin
        issue_cnt <= '0;
        rd_pend   <= 1'b0;
      end else if (state == pcfc_pkg::S_SCAN) begin
        rd_pend <= issue;
        if (issue) begin
          issue_cnt <= issue_cnt + 1'b1;
        end
      end
    end
  end

  // packet key, search position and result payload
  always_ff @(posedge clk) begin
    if (byte_acc && last_byte) begin
      cur <= info;
    end
    rd_addr <= issue_cnt[IDX_W-1:0];
    if (hit_now) begin
      hit_idx <= rd_addr;
    end
    if (miss_now) begin
      ethertype     <= cur.et;
      l4_protocol   <= cur.l4;
      packet_length <= cur.len;
      hit           <= 1'b0;
      matched_index <= 8'd0;
      packet_count  <= 64'd0;
      byte_count    <= 64'd0;
    end else if (state == pcfc_pkg::S_CUPD) begin
      ethertype     <= cur.et;
      l4_protocol   <= cur.l4;
      packet_length <= cur.len;
      hit           <= 1'b1;
      matched_index <= hit_idx_ext[7:0];
      packet_count  <= pc_wd;
      byte_count    <= bc_wd;
    end
  end

  // a result comes out only while the block is back to taking items
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == pcfc_pkg::S_IDLE)
    else $error("result strobe outside idle");

  // a miss reports no slot and no counters
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> matched_index == 8'd0 && packet_count == 64'd0 &&
                     byte_count == 64'd0)
    else $error("miss result carries slot data");

  // a search starts only from an accepted last byte
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    state == pcfc_pkg::S_SCAN && $past(state) == pcfc_pkg::S_IDLE |->
      $past(byte_acc && last_byte))
    else $error("search started without a packet end");

  // a counter update always produces a hit result next cycle
  a_update_done: assert property (@(posedge clk) disable iff (rst)
    state == pcfc_pkg::S_CUPD |=> done && hit)
    else $error("counter update without hit result");

  // the matched slot reported is the one that was compared
  a_hit_slot: assert property (@(posedge clk) disable iff (rst)
    hit_now |=> hit_idx == $past(rd_addr))
    else $error("matched slot lost");

endmodule
